// ----- rtl/scrolling_multiplexed_char_display_macros.svh -----
// ----------------------------------------------------------------------------
// Scrolling character display assertion macros
// Shared concurrent assertion forms used by the display top level.
// ----------------------------------------------------------------------------
`ifndef SCROLLING_MULTIPLEXED_CHAR_DISPLAY_MACROS_SVH
`define SCROLLING_MULTIPLEXED_CHAR_DISPLAY_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SMCD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SMCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/smcd_pkg.sv -----
// ----------------------------------------------------------------------------
// Scrolling character display package
// Field widths, request codes and shared types of the display block.
// ----------------------------------------------------------------------------
package smcd_pkg;

	localparam int FUNC_W   = 2;
	localparam int CIDX_W   = 7;
	localparam int CHAR_W   = 8;
	localparam int LEN_W    = 8;
	localparam int BRIGHT_W = 3;
	localparam int DIGIT_W  = 2;

	localparam logic [CHAR_W-1:0] SPACE_CODE = 8'd32;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_REFRESH = 2'd0,
		FUNC_SCROLL  = 2'd1,
		FUNC_WRITE   = 2'd2,
		FUNC_START   = 2'd3
	} func_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} store_ctl_t;

endpackage

// ----- rtl/smcd_if.sv -----
// ----------------------------------------------------------------------------
// Scrolling character display channels
// Request, result and brightness write channels with valid and ready.
// ----------------------------------------------------------------------------
interface smcd_in_if import smcd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [CIDX_W-1:0] char_index;
	logic [CHAR_W-1:0] char_code;
	logic [LEN_W-1:0]  message_length;
	logic              moving;

	modport source (output valid, func, char_index, char_code, message_length, moving,
		input ready);
	modport sink (input valid, func, char_index, char_code, message_length, moving,
		output ready);
endinterface

interface smcd_out_if import smcd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DIGIT_W-1:0] digit;
	logic [CHAR_W-1:0]  symbol;

	modport source (output valid, digit, symbol, input ready);
	modport sink (input valid, digit, symbol, output ready);
endinterface

interface smcd_cfg_if import smcd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [BRIGHT_W-1:0] brightness;

	modport source (output valid, brightness, input ready);
	modport sink (input valid, brightness, output ready);
endinterface

// ----- rtl/scrolling_multiplexed_char_display.sv -----
// ----------------------------------------------------------------------------
// Scrolling multiplexed character display
// Stores a message and emits a digit and character per refresh request that produces a result.
// ----------------------------------------------------------------------------
// A refresh request that produces a result is registered with the message store
// read, then held in the output register. One request is accepted every cycle
// unless a result is stalled; the single store read port serves it.
// Reset clears all counters, the message length and moving flag, and sets
// the brightness to full; the message store is not cleared.
module scrolling_multiplexed_char_display
	import smcd_pkg::*;
#(
	parameter int DIGITS    = 4,
	parameter int LEVELS    = 4,
	parameter int MSG_DEPTH = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	smcd_in_if.sink    req,
	smcd_out_if.source rsp,
	smcd_cfg_if.sink   cfg
);

`include "scrolling_multiplexed_char_display_macros.svh"

	localparam int AW     = $clog2(MSG_DEPTH);
	localparam int POS_W  = $clog2(DIGITS);
	localparam int DUTY_W = $clog2(LEVELS);
	localparam int BR_W   = $clog2(LEVELS + 1);
	localparam int IDX_W  = $clog2(255 + 2 * DIGITS + 1) + 1;

	logic signed [IDX_W-1:0] index_q;
	logic [POS_W-1:0]        pos_q;
	logic [DUTY_W-1:0]       duty_q;
	logic [LEN_W-1:0]        len_q;
	logic [LEN_W-1:0]        base_q;
	logic                    moving_q;
	logic [BR_W-1:0]         bright_q;

	logic               valid_s1;
	logic               mem_s1;
	logic [POS_W-1:0]   digit_s1;
	logic               out_valid_q;
	logic [DIGIT_W-1:0] digit_q;
	logic [CHAR_W-1:0]  symbol_q;

	func_t                   func_w;
	logic                    acc;
	logic                    out_free;
	logic [DUTY_W:0]         next_duty;
	logic                    wrap;
	logic signed [IDX_W-1:0] limit;
	logic signed [IDX_W-1:0] idx_inc;
	logic signed [IDX_W-1:0] idx_a;
	logic [POS_W:0]          pos_inc;
	logic [POS_W-1:0]        pos_a;
	logic                    in_msg;
	logic                    restart;
	logic [LEN_W:0]          addr_sum;
	logic                    addr_ok;
	logic                    emit;
	logic                    emit_mem;
	logic [POS_W-1:0]        emit_digit;
	logic [LEN_W-1:0]        len_sat;
	store_ctl_t              store_ctl;
	logic [CHAR_W-1:0]       rd_data;

	assign func_w   = func_t'(req.func);
	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || out_free;
	assign acc      = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign rsp.valid  = out_valid_q;
	assign rsp.digit  = digit_q;
	assign rsp.symbol = symbol_q;

	always_comb begin
		next_duty = {1'b0, duty_q} + 1'b1;
		wrap      = (32'(next_duty) == LEVELS);
		limit     = $signed(IDX_W'(len_q)) + $signed(IDX_W'(DIGITS));
		idx_inc   = index_q + $signed(IDX_W'(1));
		pos_inc   = {1'b0, pos_q} + 1'b1;
		if (32'(pos_inc) >= DIGITS) begin
			idx_a = idx_inc - $signed(IDX_W'(DIGITS));
			pos_a = '0;
		end else begin
			idx_a = idx_inc;
			pos_a = pos_inc[POS_W-1:0];
		end
		in_msg   = !idx_a[IDX_W-1] && (idx_a < $signed(IDX_W'(len_q)));
		restart  = !idx_a[IDX_W-1] && !in_msg && (idx_a >= limit);
		addr_sum = {1'b0, base_q} + {1'b0, LEN_W'(idx_a)};
		addr_ok  = (32'(addr_sum) < MSG_DEPTH);
		if (wrap) begin
			emit       = 1'b1;
			emit_mem   = in_msg && addr_ok;
			emit_digit = pos_a;
		end else begin
			emit       = (32'(next_duty) >= 32'(bright_q));
			emit_mem   = 1'b0;
			emit_digit = pos_q;
		end
		if (32'(req.message_length) > MSG_DEPTH) begin
			len_sat = LEN_W'(MSG_DEPTH);
		end else begin
			len_sat = req.message_length;
		end
		store_ctl.wr_en = acc && (func_w == FUNC_WRITE) && (32'(req.char_index) < MSG_DEPTH);
		store_ctl.rd_en = acc && (func_w == FUNC_REFRESH) && emit_mem;
	end

	smcd_msg_store #(
		.DEPTH(MSG_DEPTH)
	) u_store (
		.clk    (clk),
		.ctl    (store_ctl),
		.wr_addr(AW'(req.char_index)),
		.wr_data(req.char_code),
		.rd_addr(AW'(addr_sum)),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= BR_W'(LEVELS);
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.brightness != '0 && 32'(cfg.brightness) <= LEVELS) begin
				bright_q <= BR_W'(cfg.brightness);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q  <= '0;
			pos_q    <= '0;
			duty_q   <= '0;
			len_q    <= '0;
			base_q   <= '0;
			moving_q <= 1'b0;
		end else if (acc) begin
			case (func_w)
				FUNC_START: begin
					index_q <= '0;
					if (req.moving) begin
						moving_q <= 1'b1;
						base_q   <= '0;
						len_q    <= len_sat;
						pos_q    <= POS_W'(DIGITS - 1);
					end else begin
						moving_q <= 1'b0;
						pos_q    <= '0;
						if (32'(len_sat) > DIGITS) begin
							base_q <= len_sat - LEN_W'(DIGITS);
							len_q  <= LEN_W'(DIGITS);
						end else begin
							base_q <= '0;
							len_q  <= len_sat;
						end
					end
				end
				FUNC_SCROLL: begin
					if (moving_q && index_q < limit) begin
						index_q <= idx_inc;
					end
				end
				FUNC_REFRESH: begin
					if (wrap) begin
						duty_q <= '0;
						if (restart) begin
							index_q <= '0;
							pos_q   <= POS_W'(DIGITS - 1);
						end else begin
							index_q <= idx_a;
							pos_q   <= pos_a;
						end
					end else begin
						duty_q <= next_duty[DUTY_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= (func_w == FUNC_REFRESH) && emit;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mem_s1   <= emit_mem;
			digit_s1 <= emit_digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			digit_q  <= DIGIT_W'(digit_s1);
			symbol_q <= mem_s1 ? rd_data : SPACE_CODE;
		end
	end

	`SMCD_ASSERT_NEXT(a_wrap_emits, clk, arst_n, acc && func_w == FUNC_REFRESH && wrap, valid_s1, "digit wrap produced no result")
	`SMCD_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !out_free, valid_s1 && $stable(digit_s1) && $stable(mem_s1), "stalled result changed")
	`SMCD_ASSERT_NEXT(a_static_scroll, clk, arst_n, acc && func_w == FUNC_SCROLL && !moving_q, $stable(index_q), "scroll moved a static message")

endmodule

// ----- rtl/smcd_msg_store.sv -----
// ----------------------------------------------------------------------------
// Message store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module smcd_msg_store
	import smcd_pkg::*;
#(
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  store_ctl_t               ctl,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [CHAR_W-1:0]        wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [CHAR_W-1:0]        rd_data
);

	logic [CHAR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
